/* design/rthb_pkg.sv */
// Shared types and constants for the byte-scale RGB to HSV converter.
// Used by rthb_front, rthb_cell and rgb_to_hsv_byte_top; depends on nothing.
package rthb_pkg;

    // channel and result widths
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int QUOT_W   = 8;

    // hue numerator (at most 6*delta) and its divisor 2*delta
    localparam int NUM_W     = 11;
    localparam int HUE_DIV_W = 9;
    localparam int HUE_REM_W = 17;

    // saturation dividend 255*min and divisor max
    localparam int SAT_DIV_W = 8;
    localparam int SAT_REM_W = 16;

    // scale factors of the two quotients
    localparam int HUE_SCALE = 85;
    localparam int SAT_SCALE = 255;

    // largest hue code
    localparam logic [QUOT_W-1:0] HUE_MAX = 8'd254;

    // number of division cells: one quotient bit per cell
    localparam int NUM_CELLS = QUOT_W;

    // front stage result: extremes and sector numerator
    typedef struct packed {
        logic                 valid;
        logic [CHAN_W-1:0]    max_chan;
        logic [CHAN_W-1:0]    min_chan;
        logic [CHAN_W-1:0]    delta;
        logic [NUM_W-1:0]     num;
    } t_front;

    // data handed from one division cell to the next
    typedef struct packed {
        logic                 valid;
        logic                 hue_zero;
        logic                 sat_zero;
        logic [CHAN_W-1:0]    value;
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [QUOT_W-1:0]    hue_q;
        logic [SAT_REM_W-1:0] sat_rem;
        logic [SAT_DIV_W-1:0] sat_div;
        logic [QUOT_W-1:0]    sat_q;
    } t_cell_data;

endpackage

/* design/rgb_to_hsv_byte_top.sv */
// Top level of the byte-scale RGB to HSV converter: front stage, division cells, output register.
// Depends on rthb_pkg, rthb_front and rthb_cell.
//
// Usage:
//   Request channel: drive i_color_word (red 7:0, green 15:8, blue 23:16) and
//   raise start. A request is taken at every rising edge where start is high
//   and busy is low. busy is high only while reset is held; otherwise the
//   block takes one color per clock.
//   Result channel: o_valid is high for exactly one cycle with o_hue,
//   o_saturation and o_value; the receiver must take it in that cycle.
//   Path from the accepting edge to the result: one front register (max, min,
//   sector numerator), eight division cells that each settle one quotient bit
//   of both quotients, and one output register. Throughput: one result per
//   clock, set by the eight-cell chain that holds eight colors in flight.
//   Results leave in request order.
//   Reset (i_rst_n low at an edge) drops every request in flight; no state is
//   kept between colors. The receiver cannot stall, so nothing backs up.
module rgb_to_hsv_byte_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [rthb_pkg::COLOR_W-1:0] i_color_word,
    output logic                         busy,
    output logic                         o_valid,
    output logic [rthb_pkg::CHAN_W-1:0]  o_hue,
    output logic [rthb_pkg::CHAN_W-1:0]  o_saturation,
    output logic [rthb_pkg::CHAN_W-1:0]  o_value
);

    rthb_pkg::t_front     front;
    rthb_pkg::t_cell_data chain [rthb_pkg::NUM_CELLS+1];
    rthb_pkg::t_cell_data last;

    logic                        take;
    logic [rthb_pkg::CHAN_W-1:0] hue_fmt;
    logic [rthb_pkg::CHAN_W-1:0] sat_fmt;

    logic                        r_valid;
    logic [rthb_pkg::CHAN_W-1:0] r_hue;
    logic [rthb_pkg::CHAN_W-1:0] r_saturation;
    logic [rthb_pkg::CHAN_W-1:0] r_value;
    logic                        n_valid;

    // refuse requests while reset is held
    assign busy = !i_rst_n;
    assign take = start && !busy;

    rthb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_color_word (i_color_word),
        .o_front      (front)
    );

    // scale the dividends and load the first cell
    always_comb begin
        chain[0].valid    = front.valid;
        chain[0].hue_zero = (front.delta == '0);
        chain[0].sat_zero = (front.max_chan == '0);
        chain[0].value    = front.max_chan;
        chain[0].hue_rem  = rthb_pkg::HUE_REM_W'(front.num)
                            * rthb_pkg::HUE_REM_W'(rthb_pkg::HUE_SCALE);
        chain[0].hue_div  = {front.delta, 1'b0};
        chain[0].hue_q    = '0;
        chain[0].sat_rem  = rthb_pkg::SAT_REM_W'(front.min_chan)
                            * rthb_pkg::SAT_REM_W'(rthb_pkg::SAT_SCALE);
        chain[0].sat_div  = front.max_chan;
        chain[0].sat_q    = '0;
    end

    // division chain, most significant quotient bit first
    for (genvar k = 0; k < rthb_pkg::NUM_CELLS; k++) begin : g_cell
        rthb_cell #(
            .SHIFT (rthb_pkg::NUM_CELLS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_data  (chain[k]),
            .o_data  (chain[k+1])
        );
    end

    assign last = chain[rthb_pkg::NUM_CELLS];

    // gray gives hue zero, black gives saturation zero; clamp the hue
    always_comb begin
        if (last.hue_zero) begin
            hue_fmt = '0;
        end else if (last.hue_q > rthb_pkg::HUE_MAX) begin
            hue_fmt = rthb_pkg::HUE_MAX;
        end else begin
            hue_fmt = last.hue_q;
        end
        if (last.sat_zero) begin
            sat_fmt = '0;
        end else begin
            sat_fmt = rthb_pkg::CHAN_W'(rthb_pkg::SAT_SCALE) - last.sat_q;
        end
    end

    assign n_valid = last.valid;

    // hold the result for its single strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_hue        <= hue_fmt;
        r_saturation <= sat_fmt;
        r_value      <= last.value;
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_saturation;
    assign o_value      = r_value;

endmodule

/* design/rthb_front.sv */
// Front stage: splits the color, finds max and min, and forms the sector numerator.
// Depends on rthb_pkg (t_front, widths).
module rthb_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [rthb_pkg::COLOR_W-1:0] i_color_word,
    output rthb_pkg::t_front             o_front
);

    logic [rthb_pkg::CHAN_W-1:0] red;
    logic [rthb_pkg::CHAN_W-1:0] green;
    logic [rthb_pkg::CHAN_W-1:0] blue;
    logic                        red_is_max;
    logic                        green_is_max;
    logic [rthb_pkg::CHAN_W-1:0] max_chan;
    logic [rthb_pkg::CHAN_W-1:0] min_chan;
    logic [rthb_pkg::CHAN_W-1:0] delta;
    logic [rthb_pkg::NUM_W-1:0]  delta_w;
    logic [rthb_pkg::NUM_W-1:0]  num;

    rthb_pkg::t_front r_front;
    rthb_pkg::t_front n_front;

    // split the packed color
    assign red   = i_color_word[rthb_pkg::CHAN_W-1:0];
    assign green = i_color_word[2*rthb_pkg::CHAN_W-1:rthb_pkg::CHAN_W];
    assign blue  = i_color_word[3*rthb_pkg::CHAN_W-1:2*rthb_pkg::CHAN_W];

    // pick the maximum channel: red wins ties, then green
    assign red_is_max   = (red >= green) && (red >= blue);
    assign green_is_max = !red_is_max && (green >= blue);

    always_comb begin
        priority if (red_is_max) begin
            max_chan = red;
        end else if (green_is_max) begin
            max_chan = green;
        end else begin
            max_chan = blue;
        end
    end

    always_comb begin
        min_chan = red;
        if (green < min_chan) begin
            min_chan = green;
        end
        if (blue < min_chan) begin
            min_chan = blue;
        end
    end

    assign delta   = max_chan - min_chan;
    assign delta_w = rthb_pkg::NUM_W'(delta);

    // sector numerator over delta; intermediate wrap cancels, result is non-negative
    always_comb begin
        priority if (red_is_max) begin
            if (green >= blue) begin
                num = rthb_pkg::NUM_W'(green - blue);
            end else begin
                num = (delta_w << 2) + (delta_w << 1)
                      - rthb_pkg::NUM_W'(blue - green);
            end
        end else if (green_is_max) begin
            num = (delta_w << 1) + rthb_pkg::NUM_W'(blue)
                  - rthb_pkg::NUM_W'(red);
        end else begin
            num = (delta_w << 2) + rthb_pkg::NUM_W'(red)
                  - rthb_pkg::NUM_W'(green);
        end
    end

    always_comb begin
        n_front          = r_front;
        n_front.valid    = i_take;
        n_front.max_chan = max_chan;
        n_front.min_chan = min_chan;
        n_front.delta    = delta;
        n_front.num      = num;
    end

    // advance the request into the first register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else begin
            r_front.valid <= n_front.valid;
        end
        r_front.max_chan <= n_front.max_chan;
        r_front.min_chan <= n_front.min_chan;
        r_front.delta    <= n_front.delta;
        r_front.num      <= n_front.num;
    end

    assign o_front = r_front;

endmodule

/* design/rthb_cell.sv */
// One division cell: a restoring step for the hue and the saturation quotients.
// Depends on rthb_pkg (t_cell_data, widths).
module rthb_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rthb_pkg::t_cell_data i_data,
    output rthb_pkg::t_cell_data o_data
);

    logic [rthb_pkg::HUE_REM_W-1:0] hue_trial;
    logic [rthb_pkg::SAT_REM_W-1:0] sat_trial;
    logic                           hue_fits;
    logic                           sat_fits;

    rthb_pkg::t_cell_data r_data;
    rthb_pkg::t_cell_data n_data;

    // divisor aligned to this cell's quotient bit
    assign hue_trial = rthb_pkg::HUE_REM_W'(i_data.hue_div) << SHIFT;
    assign sat_trial = rthb_pkg::SAT_REM_W'(i_data.sat_div) << SHIFT;
    assign hue_fits  = i_data.hue_rem >= hue_trial;
    assign sat_fits  = i_data.sat_rem >= sat_trial;

    // subtract where the divisor fits and shift in the quotient bit
    always_comb begin
        n_data       = i_data;
        n_data.hue_q = {i_data.hue_q[rthb_pkg::QUOT_W-2:0], hue_fits};
        n_data.sat_q = {i_data.sat_q[rthb_pkg::QUOT_W-2:0], sat_fits};
        if (hue_fits) begin
            n_data.hue_rem = i_data.hue_rem - hue_trial;
        end
        if (sat_fits) begin
            n_data.sat_rem = i_data.sat_rem - sat_trial;
        end
    end

    // hand the request to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data.valid <= n_data.valid;
        end
        r_data.hue_zero <= n_data.hue_zero;
        r_data.sat_zero <= n_data.sat_zero;
        r_data.value    <= n_data.value;
        r_data.hue_rem  <= n_data.hue_rem;
        r_data.hue_div  <= n_data.hue_div;
        r_data.hue_q    <= n_data.hue_q;
        r_data.sat_rem  <= n_data.sat_rem;
        r_data.sat_div  <= n_data.sat_div;
        r_data.sat_q    <= n_data.sat_q;
    end

    assign o_data = r_data;

endmodule
